@@ rtl/camera_basis_orthonormalize_core_assert.svh @@
// assertion macros used by the orthonormal frame rtl
// needs only the clock and active-low reset names of the module that uses them
`ifndef CAMERA_BASIS_ORTHONORMALIZE_CORE_ASSERT_SVH
`define CAMERA_BASIS_ORTHONORMALIZE_CORE_ASSERT_SVH

// same-cycle implication
`define CBO_ASSERT_IMP(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbo: same-cycle check failed");

// next-cycle implication
`define CBO_ASSERT_NXT(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbo: next-cycle check failed");

`endif

@@ rtl/cbo_pkg.sv @@
// widths, latencies, side-band types and helpers for the orthonormal frame core
// no dependencies
`default_nettype none

package cbo_pkg;

    localparam int IN_W     = 24;
    localparam int OUT_W    = 18;
    localparam int FRAC_W   = 16;
    localparam int UNIT_ONE = 65536;
    localparam int MAN_W    = 31;
    localparam int SUM_W    = 64;
    localparam int ROOT_W   = 32;
    localparam int QUO_W    = 17;
    localparam int NUM_W    = 49;
    localparam int DEN_W    = ROOT_W + 1;
    localparam int CROSS_W  = IN_W + OUT_W + 1;

    localparam int PRE_LAT  = 6;
    localparam int SQRT_LAT = ROOT_W;
    localparam int DIV_LAT  = QUO_W;
    localparam int NORM_LAT = PRE_LAT + SQRT_LAT + DIV_LAT + 2;

    localparam int S_DATA_W = 6 * IN_W;
    localparam int FIELDS_W = 9 * OUT_W;
    localparam int M_DATA_W = ((FIELDS_W + 7) / 8) * 8;

    typedef struct packed {
        logic                        valid;
        logic                        zero;
        logic [2:0]                  neg;
        logic [2:0][MAN_W-1:0]       m;
    } norm_side_t;

    // magnitude (at most one) to two's complement
    function automatic logic [OUT_W-1:0] apply_sign(input logic neg,
                                                    input logic [OUT_W-1:0] mag);
        return neg ? (~mag + OUT_W'(1)) : mag;
    endfunction

endpackage

`default_nettype wire

@@ rtl/cbo_isqrt.sv @@
// pipelined integer square root, one result bit per stage
// depends on cbo_pkg
`default_nettype none

module cbo_isqrt (
    input  wire logic                        aclk,
    input  wire logic                        en,
    input  wire logic [cbo_pkg::SUM_W-1:0]   x,
    output logic      [cbo_pkg::ROOT_W-1:0]  root
);

    localparam int REM_W = cbo_pkg::ROOT_W + 3;

    logic [cbo_pkg::SUM_W-1:0]  x_reg    [cbo_pkg::ROOT_W];
    logic [REM_W-1:0]           rem_reg  [cbo_pkg::ROOT_W];
    logic [cbo_pkg::ROOT_W-1:0] root_reg [cbo_pkg::ROOT_W];

    for (genvar k = 0; k < cbo_pkg::ROOT_W; k++) begin : g_step
        logic [cbo_pkg::SUM_W-1:0]  x_in;
        logic [REM_W-1:0]           rem_in;
        logic [cbo_pkg::ROOT_W-1:0] root_in;
        logic [REM_W-1:0]           rem_sh;
        logic [REM_W-1:0]           trial;
        logic                       ge;

        if (k == 0) begin : g_first
            assign x_in    = x;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign x_in    = x_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // bring down the next two bits, try root*4+1
        assign rem_sh = {rem_in[REM_W-3:0], x_in[cbo_pkg::SUM_W-1 -: 2]};
        assign trial  = {{(REM_W-cbo_pkg::ROOT_W-2){1'b0}}, root_in, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[k]    <= {x_in[cbo_pkg::SUM_W-3:0], 2'b00};
                rem_reg[k]  <= ge ? (rem_sh - trial) : rem_sh;
                root_reg[k] <= {root_in[cbo_pkg::ROOT_W-2:0], ge};
            end
        end
    end

    assign root = root_reg[cbo_pkg::ROOT_W-1];

endmodule

`default_nettype wire

@@ rtl/cbo_div.sv @@
// pipelined restoring divider, one quotient bit per stage
// depends on cbo_pkg
`default_nettype none

module cbo_div (
    input  wire logic                       aclk,
    input  wire logic                       en,
    input  wire logic [cbo_pkg::NUM_W-1:0]  num,
    input  wire logic [cbo_pkg::DEN_W-1:0]  den,
    output logic      [cbo_pkg::QUO_W-1:0]  quo
);

    logic [cbo_pkg::NUM_W-1:0] rem_reg [cbo_pkg::QUO_W];
    logic [cbo_pkg::DEN_W-1:0] den_reg [cbo_pkg::QUO_W];
    logic [cbo_pkg::QUO_W-1:0] quo_reg [cbo_pkg::QUO_W];

    for (genvar j = 0; j < cbo_pkg::QUO_W; j++) begin : g_step
        localparam int K = cbo_pkg::QUO_W - 1 - j;
        logic [cbo_pkg::NUM_W-1:0] rem_in;
        logic [cbo_pkg::DEN_W-1:0] den_in;
        logic [cbo_pkg::QUO_W-1:0] quo_in;
        logic [cbo_pkg::NUM_W:0]   dk;
        logic                      ge;

        if (j == 0) begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = rem_reg[j-1];
            assign den_in = den_reg[j-1];
            assign quo_in = quo_reg[j-1];
        end

        assign dk = {{(cbo_pkg::NUM_W+1-cbo_pkg::DEN_W){1'b0}}, den_in} << K;
        assign ge = ({1'b0, rem_in} >= dk);

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j] <= ge ? (rem_in - dk[cbo_pkg::NUM_W-1:0]) : rem_in;
                den_reg[j] <= den_in;
                quo_reg[j] <= {quo_in[cbo_pkg::QUO_W-2:0], ge};
            end
        end
    end

    assign quo = quo_reg[cbo_pkg::QUO_W-1];

endmodule

`default_nettype wire

@@ rtl/cbo_normalize.sv @@
// pipelined 3-vector normalizer: scale to 31-bit mantissas, square-sum,
// square root, three dividers with round half away from zero; uses cbo_pkg,
// cbo_isqrt and cbo_div
`default_nettype none

module cbo_normalize #(
    parameter int IN_W = cbo_pkg::IN_W
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               en,
    input  wire logic                               in_valid,
    input  wire logic [2:0][IN_W-1:0]               c,
    output logic                                    out_valid,
    output logic      [2:0][cbo_pkg::OUT_W-1:0]     u,
    output logic                                    zero
);

    localparam int BW    = $clog2(IN_W + 1);
    localparam int MAN_W = cbo_pkg::MAN_W;

    // stage 1: magnitudes
    logic                  v1_reg;
    logic [2:0]            neg1_reg;
    logic [2:0][IN_W-1:0]  mag1_reg;
    // stage 2: largest magnitude
    logic                  v2_reg;
    logic [2:0]            neg2_reg;
    logic [2:0][IN_W-1:0]  mag2_reg;
    logic [IN_W-1:0]       top2_reg;
    // stage 3: significant bits of the largest
    logic                  v3_reg;
    logic [2:0]            neg3_reg;
    logic [2:0][IN_W-1:0]  mag3_reg;
    logic [BW-1:0]         bits3_reg;
    logic                  zero3_reg;
    // stage 4: mantissas
    logic                  v4_reg;
    logic [2:0]            neg4_reg;
    logic                  zero4_reg;
    logic [2:0][MAN_W-1:0] m4_reg;
    // stage 5: squares
    logic                  v5_reg;
    logic [2:0]            neg5_reg;
    logic                  zero5_reg;
    logic [2:0][MAN_W-1:0] m5_reg;
    logic [2:0][2*MAN_W-1:0] sq5_reg;
    // stage 6: sum of squares
    cbo_pkg::norm_side_t   side6_reg;
    logic [cbo_pkg::SUM_W-1:0] sum6_reg;

    cbo_pkg::norm_side_t   sq_dly_reg [cbo_pkg::SQRT_LAT];
    cbo_pkg::norm_side_t   prep_side_reg;
    logic [2:0][cbo_pkg::NUM_W-1:0] num_reg;
    logic [cbo_pkg::DEN_W-1:0]      den_reg;
    cbo_pkg::norm_side_t   div_dly_reg [cbo_pkg::DIV_LAT];

    logic                  out_valid_reg;
    logic                  zero_reg;
    logic [2:0][cbo_pkg::OUT_W-1:0] u_reg;

    logic [2:0][IN_W-1:0]  mag_next;
    logic [IN_W-1:0]       top_next;
    logic [BW-1:0]         bits_next;
    logic [2:0][MAN_W-1:0] m_next;
    logic [cbo_pkg::ROOT_W-1:0] root;
    logic [2:0][cbo_pkg::QUO_W-1:0] quo;
    cbo_pkg::norm_side_t   side_end;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag_next[i] = c[i][IN_W-1] ? (~c[i] + IN_W'(1)) : c[i];
        end
    end

    always_comb begin
        top_next = mag1_reg[0];
        if (mag1_reg[1] > top_next) top_next = mag1_reg[1];
        if (mag1_reg[2] > top_next) top_next = mag1_reg[2];
    end

    always_comb begin
        bits_next = '0;
        for (int b = 0; b < IN_W; b++) begin
            if (top2_reg[b]) bits_next = BW'(b + 1);
        end
    end

    // (mag << 31) >> bits puts the top magnitude's msb at bit 30
    always_comb begin
        logic [IN_W+MAN_W-1:0] wide;
        for (int i = 0; i < 3; i++) begin
            wide      = {mag3_reg[i], {MAN_W{1'b0}}} >> bits3_reg;
            m_next[i] = wide[MAN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            v4_reg           <= 1'b0;
            v5_reg           <= 1'b0;
            side6_reg.valid  <= 1'b0;
        end else if (en) begin
            v1_reg           <= in_valid;
            v2_reg           <= v1_reg;
            v3_reg           <= v2_reg;
            v4_reg           <= v3_reg;
            v5_reg           <= v4_reg;
            side6_reg.valid  <= v5_reg;
            side6_reg.zero   <= zero5_reg;
            side6_reg.neg    <= neg5_reg;
            side6_reg.m      <= m5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                neg1_reg[i] <= c[i][IN_W-1];
            end
            mag1_reg   <= mag_next;
            neg2_reg   <= neg1_reg;
            mag2_reg   <= mag1_reg;
            top2_reg   <= top_next;
            neg3_reg   <= neg2_reg;
            mag3_reg   <= mag2_reg;
            bits3_reg  <= bits_next;
            zero3_reg  <= (top2_reg == '0);
            neg4_reg   <= neg3_reg;
            zero4_reg  <= zero3_reg;
            m4_reg     <= m_next;
            neg5_reg   <= neg4_reg;
            zero5_reg  <= zero4_reg;
            m5_reg     <= m4_reg;
            for (int i = 0; i < 3; i++) begin
                sq5_reg[i] <= m4_reg[i] * m4_reg[i];
            end
            sum6_reg <= {2'b00, sq5_reg[0]} + {2'b00, sq5_reg[1]} + {2'b00, sq5_reg[2]};
        end
    end

    cbo_isqrt u_isqrt (
        .aclk (aclk),
        .en   (en),
        .x    (sum6_reg),
        .root (root)
    );

    // side data rides alongside the root and quotient pipelines
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < cbo_pkg::SQRT_LAT; k++) sq_dly_reg[k].valid <= 1'b0;
            for (int k = 0; k < cbo_pkg::DIV_LAT; k++) div_dly_reg[k].valid <= 1'b0;
            prep_side_reg.valid <= 1'b0;
        end else if (en) begin
            sq_dly_reg[0] <= side6_reg;
            for (int k = 1; k < cbo_pkg::SQRT_LAT; k++) sq_dly_reg[k] <= sq_dly_reg[k-1];
            prep_side_reg <= sq_dly_reg[cbo_pkg::SQRT_LAT-1];
            div_dly_reg[0] <= prep_side_reg;
            for (int k = 1; k < cbo_pkg::DIV_LAT; k++) div_dly_reg[k] <= div_dly_reg[k-1];
        end
    end

    // numerator 2*m*2^16 + n over 2*n gives the rounded quotient
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                num_reg[i] <= {1'b0, sq_dly_reg[cbo_pkg::SQRT_LAT-1].m[i], 17'd0}
                            + {{(cbo_pkg::NUM_W-cbo_pkg::ROOT_W){1'b0}}, root};
            end
            den_reg <= {root, 1'b0};
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane
        cbo_div u_div (
            .aclk (aclk),
            .en   (en),
            .num  (num_reg[i]),
            .den  (den_reg),
            .quo  (quo[i])
        );
    end

    assign side_end = div_dly_reg[cbo_pkg::DIV_LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= side_end.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg <= side_end.zero;
            for (int i = 0; i < 3; i++) begin
                u_reg[i] <= side_end.zero ? '0
                          : cbo_pkg::apply_sign(side_end.neg[i], {1'b0, quo[i]});
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign u         = u_reg;
    assign zero      = zero_reg;

endmodule

`default_nettype wire

@@ rtl/camera_basis_orthonormalize_core.sv @@
// top level of the orthonormal camera frame core: two normalizers, the two
// cross products, the output skid register; uses cbo_pkg, cbo_normalize
//
//  channel | ports                      | carries
//  --------+----------------------------+-----------------------------------------
//  s_      | s_tvalid s_tready s_tdata  | forward and up hint, Q7.16, one word
//  m_      | m_tvalid m_tready m_tdata  | right, new up, unit forward (Q1.16),
//          | m_tuser                    | degenerate flag
//
//  one word accepted per cycle while the skid register is empty; the path from
//  accept to m_tvalid runs through two 57-stage normalizers, each with a 32-stage
//  square root and a 17-stage divider, four cross-product stages and the output register
//  aresetn is synchronous, active low, and empties every stage
//  the whole pipeline holds when the skid register behind the output is full;
//  s_tready is low only then, so a waiting result does not block input
`default_nettype none

module camera_basis_orthonormalize_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // fwd_x, fwd_y, fwd_z, up_hint_x, up_hint_y, up_hint_z (24 bits each)
    input  wire logic [cbo_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // right_x/y/z, new_up_x/y/z, unit_fwd_x/y/z (18 bits each), zero pad
    output logic      [cbo_pkg::M_DATA_W-1:0]  m_tdata,
    // degenerate
    output logic                               m_tuser
);

    `include "camera_basis_orthonormalize_core_assert.svh"

    localparam int IN_W    = cbo_pkg::IN_W;
    localparam int OUT_W   = cbo_pkg::OUT_W;
    localparam int CROSS_W = cbo_pkg::CROSS_W;
    localparam int PROD_W  = IN_W + OUT_W;
    localparam int UP_W    = 2 * OUT_W;
    localparam int NU_W    = UP_W + 1;
    localparam int VEC_W   = 3 * OUT_W;
    localparam int UF_LO   = 2 * VEC_W;

    typedef struct packed {
        logic                  zero;
        logic [2:0][OUT_W-1:0] uf;
    } fwd_side_t;

    logic en;

    logic [2:0][IN_W-1:0]  fwd_c;
    logic [2:0][IN_W-1:0]  up_c;
    logic [2:0][IN_W-1:0]  up_dly_reg [cbo_pkg::NORM_LAT];

    logic                  n1_valid;
    logic [2:0][OUT_W-1:0] n1_u;
    logic                  n1_zero;

    logic                      x1_valid_reg;
    logic signed [PROD_W-1:0]  xp_reg [6];
    fwd_side_t                 x1_side_reg;
    logic                      x2_valid_reg;
    logic [2:0][CROSS_W-1:0]   cr_reg;
    fwd_side_t                 x2_side_reg;
    fwd_side_t                 uf_dly_reg [cbo_pkg::NORM_LAT];

    logic                  n2_valid;
    logic [2:0][OUT_W-1:0] n2_u;
    logic                  n2_zero;

    logic                      p1_valid_reg;
    logic signed [UP_W-1:0]    up_p_reg [6];
    logic [2:0][OUT_W-1:0]     p1_uf_reg;
    logic [2:0][OUT_W-1:0]     p1_rt_reg;
    logic                      p1_degen_reg;

    logic                      p2_valid_reg;
    logic [2:0][OUT_W-1:0]     p2_uf_reg;
    logic [2:0][OUT_W-1:0]     p2_rt_reg;
    logic [2:0][OUT_W-1:0]     p2_nu_reg;
    logic                      p2_degen_reg;
    logic [2:0][OUT_W-1:0]     nu_next;

    logic                          push;
    logic [cbo_pkg::M_DATA_W-1:0]  push_data;
    logic                          m_tvalid_reg;
    logic [cbo_pkg::M_DATA_W-1:0]  m_data_reg;
    logic                          m_user_reg;
    logic                          skid_valid_reg;
    logic [cbo_pkg::M_DATA_W-1:0]  skid_data_reg;
    logic                          skid_user_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign fwd_c    = s_tdata[3*IN_W-1:0];
    assign up_c     = s_tdata[6*IN_W-1:3*IN_W];

    cbo_normalize #(.IN_W(IN_W)) u_norm_fwd (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .c         (fwd_c),
        .out_valid (n1_valid),
        .u         (n1_u),
        .zero      (n1_zero)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            up_dly_reg[0] <= up_c;
            for (int k = 1; k < cbo_pkg::NORM_LAT; k++) up_dly_reg[k] <= up_dly_reg[k-1];
        end
    end

    // right = up_hint x unit_fwd, exact
    always_ff @(posedge aclk) begin
        logic [2:0][IN_W-1:0] up;
        up = up_dly_reg[cbo_pkg::NORM_LAT-1];
        if (en) begin
            xp_reg[0] <= $signed(up[1]) * $signed(n1_u[2]);
            xp_reg[1] <= $signed(up[2]) * $signed(n1_u[1]);
            xp_reg[2] <= $signed(up[2]) * $signed(n1_u[0]);
            xp_reg[3] <= $signed(up[0]) * $signed(n1_u[2]);
            xp_reg[4] <= $signed(up[0]) * $signed(n1_u[1]);
            xp_reg[5] <= $signed(up[1]) * $signed(n1_u[0]);
            x1_side_reg.zero <= n1_zero;
            x1_side_reg.uf   <= n1_u;
            for (int i = 0; i < 3; i++) begin
                cr_reg[i] <= CROSS_W'($signed({xp_reg[2*i][PROD_W-1], xp_reg[2*i]})
                           - $signed({xp_reg[2*i+1][PROD_W-1], xp_reg[2*i+1]}));
            end
            x2_side_reg <= x1_side_reg;
            uf_dly_reg[0] <= x2_side_reg;
            for (int k = 1; k < cbo_pkg::NORM_LAT; k++) uf_dly_reg[k] <= uf_dly_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x1_valid_reg <= 1'b0;
            x2_valid_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else if (en) begin
            x1_valid_reg <= n1_valid;
            x2_valid_reg <= x1_valid_reg;
            p1_valid_reg <= n2_valid;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    cbo_normalize #(.IN_W(CROSS_W)) u_norm_right (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (x2_valid_reg),
        .c         (cr_reg),
        .out_valid (n2_valid),
        .u         (n2_u),
        .zero      (n2_zero)
    );

    // new up = unit_fwd x right in Q2.32
    always_ff @(posedge aclk) begin
        fwd_side_t fs;
        fs = uf_dly_reg[cbo_pkg::NORM_LAT-1];
        if (en) begin
            up_p_reg[0] <= $signed(fs.uf[1]) * $signed(n2_u[2]);
            up_p_reg[1] <= $signed(fs.uf[2]) * $signed(n2_u[1]);
            up_p_reg[2] <= $signed(fs.uf[2]) * $signed(n2_u[0]);
            up_p_reg[3] <= $signed(fs.uf[0]) * $signed(n2_u[2]);
            up_p_reg[4] <= $signed(fs.uf[0]) * $signed(n2_u[1]);
            up_p_reg[5] <= $signed(fs.uf[1]) * $signed(n2_u[0]);
            p1_uf_reg    <= fs.uf;
            p1_rt_reg    <= n2_u;
            p1_degen_reg <= fs.zero | n2_zero;
        end
    end

    // round magnitude half away from zero back to Q1.16, clamp to one
    always_comb begin
        logic signed [NU_W-1:0] d;
        logic [NU_W:0]          mag;
        logic [NU_W:0]          rnd;
        logic [OUT_W-1:0]       q;
        for (int i = 0; i < 3; i++) begin
            d   = $signed({up_p_reg[2*i][UP_W-1], up_p_reg[2*i]})
                - $signed({up_p_reg[2*i+1][UP_W-1], up_p_reg[2*i+1]});
            mag = d[NU_W-1] ? ((NU_W+1)'(~d) + (NU_W+1)'(1)) : (NU_W+1)'(d);
            rnd = (mag + (NU_W+1)'(32768)) >> cbo_pkg::FRAC_W;
            q   = (rnd > (NU_W+1)'(cbo_pkg::UNIT_ONE)) ? OUT_W'(cbo_pkg::UNIT_ONE)
                                                       : rnd[OUT_W-1:0];
            nu_next[i] = cbo_pkg::apply_sign(d[NU_W-1], q);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_degen_reg <= p1_degen_reg;
            p2_uf_reg    <= p1_degen_reg ? '0 : p1_uf_reg;
            p2_rt_reg    <= p1_degen_reg ? '0 : p1_rt_reg;
            p2_nu_reg    <= p1_degen_reg ? '0 : nu_next;
        end
    end

    assign push      = p2_valid_reg && en;
    assign push_data = {{(cbo_pkg::M_DATA_W-cbo_pkg::FIELDS_W){1'b0}},
                        p2_uf_reg, p2_nu_reg, p2_rt_reg};

    // output register with one skid entry behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_tvalid_reg && m_tready) begin
            if (skid_valid_reg) begin
                m_data_reg     <= skid_data_reg;
                m_user_reg     <= skid_user_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                m_tvalid_reg <= push;
                if (push) begin
                    m_data_reg <= push_data;
                    m_user_reg <= p2_degen_reg;
                end
            end
        end else if (push) begin
            if (!m_tvalid_reg) begin
                m_tvalid_reg <= 1'b1;
                m_data_reg   <= push_data;
                m_user_reg   <= p2_degen_reg;
            end else begin
                skid_valid_reg <= 1'b1;
                skid_data_reg  <= push_data;
                skid_user_reg  <= p2_degen_reg;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    `CBO_ASSERT_IMP(a_skid_behind_head, aclk, aresetn, skid_valid_reg, m_tvalid_reg)
    `CBO_ASSERT_IMP(a_degen_all_zero, aclk, aresetn, m_tvalid_reg && m_user_reg, m_data_reg[cbo_pkg::FIELDS_W-1:0] == '0)
    `CBO_ASSERT_IMP(a_frame_nonzero, aclk, aresetn, m_tvalid_reg && !m_user_reg, m_data_reg[UF_LO +: VEC_W] != '0 && m_data_reg[0 +: VEC_W] != '0)
    `CBO_ASSERT_NXT(a_skid_holds, aclk, aresetn, skid_valid_reg && !m_tready, skid_valid_reg && !s_tready)

endmodule

`default_nettype wire
